// ===== rtl/b64c_pkg.sv =====
// Shared types, constants and character mapping functions for the Base64 codec.
`default_nettype none

package b64c_pkg;

	localparam int unsigned CFG_IDX_W   = 2;
	localparam int unsigned CFG_DATA_W  = 8;
	localparam int unsigned NUM_SLOTS   = 4;
	localparam int unsigned SLOT_IDX_W  = $clog2(NUM_SLOTS);
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] PAD_CHAR    = 8'h3D; // '='
	localparam logic [7:0] UPPER_FIRST = 8'h41; // 'A'
	localparam logic [7:0] UPPER_LAST  = 8'h5A; // 'Z'
	localparam logic [7:0] LOWER_FIRST = 8'h61; // 'a'
	localparam logic [7:0] LOWER_LAST  = 8'h7A; // 'z'
	localparam logic [7:0] DIGIT_FIRST = 8'h30; // '0'
	localparam logic [7:0] DIGIT_LAST  = 8'h39; // '9'

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DECODE_MODE = 2'd0,
		CFG_INDEX62     = 2'd1,
		CFG_INDEX63     = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		SLOT_SEXTET = 3'd0, // data[5:0] goes through the alphabet
		SLOT_PAD    = 3'd1, // '=' character
		SLOT_BYTE   = 3'd2, // decoded byte as is
		SLOT_BAD    = 3'd3, // invalid character flag
		SLOT_MARK   = 3'd4  // bare end marker
	} slot_kind_t;

	typedef enum logic [1:0] {
		CH_DATA = 2'd0,
		CH_PAD  = 2'd1,
		CH_BAD  = 2'd2
	} char_class_t;

	typedef struct packed {
		char_class_t cls;
		logic [5:0]  sextet;
	} char_info_t;

	typedef struct packed {
		slot_kind_t kind;
		logic [7:0] data;
	} slot_t;

	// One queue entry: all results caused by one input transaction.
	typedef struct packed {
		logic                  last;
		logic [SLOT_IDX_W-1:0] last_idx;
		slot_t [NUM_SLOTS-1:0] slots;
	} entry_t;

	function automatic char_info_t char_sextet(input logic [7:0] c, input logic [7:0] i62,
			input logic [7:0] i63);
		char_info_t r;
		r.cls    = CH_BAD;
		r.sextet = '0;
		if (c == PAD_CHAR) begin
			r.cls = CH_PAD;
		end else if (c >= UPPER_FIRST && c <= UPPER_LAST) begin
			r.cls    = CH_DATA;
			r.sextet = 6'(c - UPPER_FIRST);
		end else if (c >= LOWER_FIRST && c <= LOWER_LAST) begin
			r.cls    = CH_DATA;
			r.sextet = 6'(c - LOWER_FIRST + 8'd26);
		end else if (c >= DIGIT_FIRST && c <= DIGIT_LAST) begin
			r.cls    = CH_DATA;
			r.sextet = 6'(c - DIGIT_FIRST + 8'd52);
		end else if (c == i62) begin
			r.cls    = CH_DATA;
			r.sextet = 6'd62;
		end else if (c == i63) begin
			r.cls    = CH_DATA;
			r.sextet = 6'd63;
		end
		return r;
	endfunction

	function automatic logic [7:0] sextet_char(input logic [5:0] s, input logic [7:0] i62,
			input logic [7:0] i63);
		logic [7:0] w;
		logic [7:0] r;
		w = {2'b00, s};
		if (s < 6'd26) begin
			r = UPPER_FIRST + w;
		end else if (s < 6'd52) begin
			r = LOWER_FIRST + w - 8'd26;
		end else if (s < 6'd62) begin
			r = DIGIT_FIRST + w - 8'd52;
		end else if (s == 6'd62) begin
			r = i62;
		end else begin
			r = i63;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/b64c_if.sv =====
// Stream channel interfaces for the Base64 codec input and output.
`default_nettype none

interface b64c_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source(output valid, in_byte, in_last, input ready);
	modport sink(input valid, in_byte, in_last, output ready);
endinterface

interface b64c_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_valid;
	logic       bad_char;
	logic       out_last;

	modport source(output valid, out_byte, out_valid, bad_char, out_last, input ready);
	modport sink(input valid, out_byte, out_valid, bad_char, out_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/b64c_front.sv =====
// Front end: accepts input transactions, tracks group state, builds result entries.
`default_nettype none

module b64c_front
	import b64c_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       decode_mode,
	input  wire logic       mode_wr,
	input  wire logic [7:0] index62_char,
	input  wire logic [7:0] index63_char,
	b64c_in_if.sink         in_ch,
	input  wire logic       q_full,
	output logic            push,
	output entry_t          push_entry
);

	logic [1:0] phase_q;
	logic [5:0] held_q;
	logic [1:0] phase_d;
	logic [5:0] held_d;
	logic [2:0] n_res;
	logic       accept;
	logic [7:0] b;
	char_info_t info;
	entry_t     ent;

	assign in_ch.ready = !q_full;
	assign accept      = in_ch.valid && !q_full;
	assign b           = in_ch.in_byte;

	always_comb begin
		ent     = '0;
		n_res   = 3'd0;
		phase_d = phase_q;
		held_d  = held_q;
		info    = char_sextet(b, index62_char, index63_char);
		if (!decode_mode) begin
			case (phase_q)
				2'd1: begin
					ent.slots[0].kind = SLOT_SEXTET;
					ent.slots[0].data = {2'b00, held_q | {2'b00, b[7:4]}};
					held_d  = {b[3:0], 2'b00};
					phase_d = 2'd2;
					n_res   = 3'd1;
				end
				2'd2: begin
					ent.slots[0].kind = SLOT_SEXTET;
					ent.slots[0].data = {2'b00, held_q | {4'b0000, b[7:6]}};
					ent.slots[1].kind = SLOT_SEXTET;
					ent.slots[1].data = {2'b00, b[5:0]};
					held_d  = 6'd0;
					phase_d = 2'd0;
					n_res   = 3'd2;
				end
				default: begin
					// phase 3 cannot occur in encode and is taken as a new group
					ent.slots[0].kind = SLOT_SEXTET;
					ent.slots[0].data = {2'b00, b[7:2]};
					held_d  = {b[1:0], 4'b0000};
					phase_d = 2'd1;
					n_res   = 3'd1;
				end
			endcase
			if (in_ch.in_last) begin
				if (phase_d == 2'd1) begin
					ent.slots[1].kind = SLOT_SEXTET;
					ent.slots[1].data = {2'b00, held_d};
					ent.slots[2].kind = SLOT_PAD;
					ent.slots[3].kind = SLOT_PAD;
					n_res = 3'd4;
				end else if (phase_d == 2'd2) begin
					ent.slots[1].kind = SLOT_SEXTET;
					ent.slots[1].data = {2'b00, held_d};
					ent.slots[2].kind = SLOT_PAD;
					n_res = 3'd3;
				end
			end
		end else begin
			case (info.cls)
				CH_BAD: begin
					ent.slots[0].kind = SLOT_BAD;
					n_res = 3'd1;
				end
				CH_DATA: begin
					ent.slots[0].kind = SLOT_BYTE;
					case (phase_q)
						2'd0: begin
							held_d  = info.sextet;
							phase_d = 2'd1;
						end
						2'd1: begin
							ent.slots[0].data = {held_q, info.sextet[5:4]};
							held_d  = {2'b00, info.sextet[3:0]};
							phase_d = 2'd2;
							n_res   = 3'd1;
						end
						2'd2: begin
							ent.slots[0].data = {held_q[3:0], info.sextet[5:2]};
							held_d  = {4'b0000, info.sextet[1:0]};
							phase_d = 2'd3;
							n_res   = 3'd1;
						end
						default: begin
							ent.slots[0].data = {held_q[1:0], info.sextet};
							held_d  = 6'd0;
							phase_d = 2'd0;
							n_res   = 3'd1;
						end
					endcase
				end
				default: begin
					// '=' is skipped
				end
			endcase
		end
		if (in_ch.in_last) begin
			if (n_res == 3'd0) begin
				ent.slots[0].kind = SLOT_MARK;
				ent.slots[0].data = 8'd0;
				n_res = 3'd1;
			end
			phase_d = 2'd0;
			held_d  = 6'd0;
		end
		ent.last     = in_ch.in_last;
		ent.last_idx = SLOT_IDX_W'(n_res - 3'd1);
	end

	assign push       = accept && (n_res != 3'd0);
	assign push_entry = ent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 2'd0;
			held_q  <= 6'd0;
		end else if (mode_wr) begin
			phase_q <= 2'd0;
			held_q  <= 6'd0;
		end else if (accept) begin
			phase_q <= phase_d;
			held_q  <= held_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/b64c_queue.sv =====
// Small register queue of result entries between front and back ends.
`default_nettype none

module b64c_queue
	import b64c_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire entry_t push_entry,
	input  wire logic   pop,
	output entry_t      head,
	output logic        full,
	output logic        empty
);

	entry_t              store_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = store_q[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
		logic [QPTR_W-1:0] r;
		if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/b64c_back.sv =====
// Back end: walks the slots of the head entry and drives one result per transaction.
`default_nettype none

module b64c_back
	import b64c_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] index62_char,
	input  wire logic [7:0] index63_char,
	input  wire entry_t     head,
	input  wire logic       q_empty,
	output logic            pop,
	b64c_out_if.source      out_ch
);

	logic [SLOT_IDX_W-1:0] slot_idx_q;
	logic                  valid_q;
	logic [7:0]            byte_q;
	logic                  data_valid_q;
	logic                  bad_q;
	logic                  last_q;

	slot_t      cur;
	logic       load;
	logic       final_slot;
	logic [7:0] res_byte;
	logic       res_valid;
	logic       res_bad;

	assign cur        = head.slots[slot_idx_q];
	assign final_slot = (slot_idx_q == head.last_idx);
	assign load       = !q_empty && (!valid_q || out_ch.ready);
	assign pop        = load && final_slot;

	always_comb begin
		res_byte  = 8'd0;
		res_valid = 1'b0;
		res_bad   = 1'b0;
		case (cur.kind)
			SLOT_SEXTET: begin
				res_byte  = sextet_char(cur.data[5:0], index62_char, index63_char);
				res_valid = 1'b1;
			end
			SLOT_PAD: begin
				res_byte  = PAD_CHAR;
				res_valid = 1'b1;
			end
			SLOT_BYTE: begin
				res_byte  = cur.data;
				res_valid = 1'b1;
			end
			SLOT_BAD: begin
				res_bad = 1'b1;
			end
			default: begin
				// bare end marker
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= 1'b0;
			slot_idx_q <= '0;
		end else begin
			if (load) begin
				valid_q    <= 1'b1;
				slot_idx_q <= final_slot ? '0 : slot_idx_q + 1'b1;
			end else if (out_ch.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q       <= res_byte;
			data_valid_q <= res_valid;
			bad_q        <= res_bad;
			last_q       <= head.last && final_slot;
		end
	end

	assign out_ch.valid     = valid_q;
	assign out_ch.out_byte  = byte_q;
	assign out_ch.out_valid = data_valid_q;
	assign out_ch.bad_char  = bad_q;
	assign out_ch.out_last  = last_q;

endmodule

`default_nettype wire

// ===== rtl/base64_stream_codec.sv =====
// Top level of the streaming Base64 codec: configuration registers, front, queue, back.
//
//  channel   role    handshake        payload
//  in_ch     sink    valid / ready    in_byte[7:0], in_last
//  out_ch    source  valid / ready    out_byte[7:0], out_valid, bad_char, out_last
//  cfg       write   cfg_we           cfg_idx[1:0], cfg_data[7:0]
//
// An input transaction is taken every cycle while the entry queue has room; the back end
// sends one result per cycle unless the output channel stalls, and an input gives up to 4
// results for an encoded final byte. A result passes the queue store and the output register.
// Reset clears group state, the queue and the output register; no clearing pass.
// Front and back stall on their own through the two-entry queue.
`default_nettype none

module base64_stream_codec
	import b64c_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	b64c_in_if.sink                    in_ch,
	b64c_out_if.source                 out_ch
);

	logic       decode_mode_q;
	logic [7:0] index62_q;
	logic [7:0] index63_q;
	logic       mode_wr;

	logic   push;
	entry_t push_entry;
	logic   pop;
	entry_t head;
	logic   q_full;
	logic   q_empty;

	assign mode_wr = cfg_we && (cfg_idx == CFG_DECODE_MODE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decode_mode_q <= 1'b0;
			index62_q     <= 8'd43;
			index63_q     <= 8'd47;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_DECODE_MODE: decode_mode_q <= cfg_data[0];
				CFG_INDEX62:     index62_q     <= cfg_data[7:0];
				CFG_INDEX63:     index63_q     <= cfg_data[7:0];
				default: begin
					// unmapped index, ignored
				end
			endcase
		end
	end

	b64c_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.decode_mode  (decode_mode_q),
		.mode_wr      (mode_wr),
		.index62_char (index62_q),
		.index63_char (index63_q),
		.in_ch        (in_ch),
		.q_full       (q_full),
		.push         (push),
		.push_entry   (push_entry)
	);

	b64c_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.full       (q_full),
		.empty      (q_empty)
	);

	b64c_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.index62_char (index62_q),
		.index63_char (index63_q),
		.head         (head),
		.q_empty      (q_empty),
		.pop          (pop),
		.out_ch       (out_ch)
	);

endmodule

`default_nettype wire

// ===== rtl/b64c_checker.sv =====
// Port-level assertions for the Base64 codec and their bind to the top level.
`default_nettype none

module b64c_checker
	import b64c_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  cfg_we,
	input wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input wire logic [CFG_DATA_W-1:0] cfg_data,
	input wire logic                  out_hs_valid,
	input wire logic                  out_hs_ready,
	input wire logic [7:0]            out_byte,
	input wire logic                  out_valid,
	input wire logic                  bad_char,
	input wire logic                  out_last
);

	logic mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_we && cfg_idx == CFG_DECODE_MODE) begin
			mode_q <= cfg_data[0];
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_hs_valid && !out_hs_ready |=> out_hs_valid)
		else $error("output transaction dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_hs_valid && !out_hs_ready |=> $stable(out_byte) && $stable(out_valid)
			&& $stable(bad_char) && $stable(out_last))
		else $error("output payload changed while stalled");

	a_encode_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_hs_valid && !mode_q |-> out_valid && !bad_char)
		else $error("encode result without data or with error flag");

	a_bad_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_hs_valid && bad_char |-> !out_valid && out_byte == 8'd0)
		else $error("invalid character result carries data");

	a_marker_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_hs_valid && !out_valid && !bad_char |-> out_last && out_byte == 8'd0)
		else $error("empty result that is not an end marker");

endmodule

bind base64_stream_codec b64c_checker u_b64c_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cfg_we       (cfg_we),
	.cfg_idx      (cfg_idx),
	.cfg_data     (cfg_data),
	.out_hs_valid (out_ch.valid),
	.out_hs_ready (out_ch.ready),
	.out_byte     (out_ch.out_byte),
	.out_valid    (out_ch.out_valid),
	.bad_char     (out_ch.bad_char),
	.out_last     (out_ch.out_last)
);

`default_nettype wire
